/* src/brci_pkg.sv */
// shared types and constants for the barycentric row color interpolator
package brci_pkg;

  localparam int MAX_SPAN_DEF   = 64;
  localparam int COORD_BITS_DEF = 12;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int CNT_W     = 7;

  // multiply-accumulate pairs: u, v, then start and step for each of 4 channels
  localparam int NUM_PAIRS = 10;
  localparam int PAIR_W    = 4;
  localparam int SEQ_W     = 5;

  localparam logic [PAIR_W-1:0] PAIR_U = 4'd0;
  localparam logic [PAIR_W-1:0] PAIR_V = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CV0 = 3'd0,
    REG_CV1 = 3'd1,
    REG_CV2 = 3'd2,
    REG_MU  = 3'd3,
    REG_MV  = 3'd4,
    REG_MO  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic              first;
    logic [PAIR_W-1:0] pair;
    logic              wb_en;
    logic [PAIR_W-1:0] wb_pair;
    logic              issue;
    logic              issue_last;
  } cmd_t;

  typedef struct packed {
    logic adv;
  } stat_t;

endpackage

/* src/brci_ctrl.sv */
// sequencer: setup multiply-accumulate schedule and per-pixel issue
module brci_ctrl #(
  parameter int MAX_SPAN = brci_pkg::MAX_SPAN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [brci_pkg::CNT_W-1:0]    span_count,
  input  brci_pkg::stat_t               stat,
  output brci_pkg::cmd_t                cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_PIX   = 3'b100
  } state_t;

  localparam logic [brci_pkg::SEQ_W-1:0] SEQ_END = brci_pkg::SEQ_W'(2 * brci_pkg::NUM_PAIRS);
  localparam logic [brci_pkg::CNT_W-1:0] MAX_CNT = brci_pkg::CNT_W'(MAX_SPAN);

  state_t                       state, state_next;
  logic [brci_pkg::SEQ_W-1:0]   seq, seq_next;
  logic [brci_pkg::CNT_W-1:0]   left, left_next;
  logic [brci_pkg::CNT_W-1:0]   count_cl;

  assign count_cl = (span_count > MAX_CNT) ? MAX_CNT : span_count;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    seq_next   = seq;
    left_next  = left;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          seq_next  = '0;
          left_next = count_cl;
          if (count_cl != '0) state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.mul_en  = (seq != SEQ_END);
        cmd.first   = ~seq[0];
        cmd.pair    = seq[brci_pkg::SEQ_W-1:1];
        cmd.wb_en   = (seq >= brci_pkg::SEQ_W'(2)) && !seq[0];
        cmd.wb_pair = seq[brci_pkg::SEQ_W-1:1] - brci_pkg::PAIR_W'(1);
        seq_next    = seq + brci_pkg::SEQ_W'(1);
        if (seq == SEQ_END) state_next = S_PIX;
      end
      S_PIX: begin
        cmd.issue      = stat.adv;
        cmd.issue_last = (left == brci_pkg::CNT_W'(1));
        if (stat.adv) begin
          left_next = left - brci_pkg::CNT_W'(1);
          if (left == brci_pkg::CNT_W'(1)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seq   <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      seq   <= seq_next;
      left  <= left_next;
    end
  end

endmodule

/* src/brci_dp.sv */
// datapath: config registers, shared mac, color accumulators, pixel pipeline
module brci_dp #(
  parameter int COORD_BITS = brci_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [brci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [brci_pkg::CFG_W-1:0]        cfg_data,
  input  logic [11:0]                       start_x,
  input  logic [11:0]                       row_y,
  input  logic                              out_ready,
  input  brci_pkg::cmd_t                    cmd,
  output brci_pkg::stat_t                   stat,
  output logic                              out_valid,
  output logic [31:0]                       pixel,
  output logic                              last
);

  localparam logic [16:0] CMASK = (17'd1 << COORD_BITS) - 17'd1;

  logic [63:0] cv0, cv1, cv2, mu, mv, mo;

  logic signed [17:0] x2, y2;
  logic signed [33:0] u_r, v_r;
  logic signed [52:0] acc;

  logic signed [23:0] acc_c [4];
  logic signed [23:0] step_c [4];

  function automatic logic [15:0] chan(input logic [63:0] r, input logic [1:0] k);
    logic [15:0] c;
    case (k)
      2'd0:    c = r[63:48];
      2'd1:    c = r[47:32];
      2'd2:    c = r[31:16];
      default: c = r[15:0];
    endcase
    return c;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [52:0] v);
    logic signed [23:0] r;
    if (v > 53'sd8388607)       r = 24'sd8388607;
    else if (v < -53'sd8388608) r = -24'sd8388608;
    else                        r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [33:0] sat34(input logic signed [52:0] v);
    logic signed [33:0] r;
    if (v > 53'sd8589934591)       r = 34'sd8589934591;
    else if (v < -53'sd8589934592) r = -34'sd8589934592;
    else                           r = v[33:0];
    return r;
  endfunction

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      cv0 <= '0;
      cv1 <= '0;
      cv2 <= '0;
      mu  <= 64'd1 << 48;
      mv  <= 64'd1 << 16;
      mo  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brci_pkg::REG_CV0: cv0 <= cfg_data;
        brci_pkg::REG_CV1: cv1 <= cfg_data;
        brci_pkg::REG_CV2: cv2 <= cfg_data;
        brci_pkg::REG_MU:  mu  <= cfg_data;
        brci_pkg::REG_MV:  mv  <= cfg_data;
        brci_pkg::REG_MO:  mo  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel centers in half units
  logic [15:0] xm, ym;
  assign xm = 16'(start_x) & CMASK[15:0];
  assign ym = 16'(row_y) & CMASK[15:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x2 <= {1'b0, xm, 1'b1};
      y2 <= {1'b0, ym, 1'b1};
    end
  end

  // shared multiply-accumulate
  logic signed [31:0] ux, uy, vx, vy, uo, vo;
  assign ux = mu[63:32];
  assign uy = mu[31:0];
  assign vx = mv[63:32];
  assign vy = mv[31:0];
  assign uo = mo[63:32];
  assign vo = mo[31:0];

  logic [3:0]         pm2;
  logic [1:0]         kc;
  logic [15:0]        c0, c1, c2;
  logic signed [17:0] d1, d2;
  logic signed [33:0] op_a;
  logic signed [17:0] op_b;
  logic signed [52:0] init;
  logic signed [51:0] prod;

  assign pm2 = cmd.pair - 4'd2;
  assign kc  = pm2[2:1];
  assign c0  = chan(cv0, kc);
  assign c1  = chan(cv1, kc);
  assign c2  = chan(cv2, kc);
  assign d1  = 18'(signed'({1'b0, c1}) - signed'({1'b0, c0}));
  assign d2  = 18'(signed'({1'b0, c2}) - signed'({1'b0, c0}));

  always_comb begin
    case (cmd.pair)
      brci_pkg::PAIR_U: begin
        op_a = cmd.first ? 34'(ux) : 34'(uy);
        op_b = cmd.first ? x2 : y2;
        init = 53'(uo) <<< 1;
      end
      brci_pkg::PAIR_V: begin
        op_a = cmd.first ? 34'(vx) : 34'(vy);
        op_b = cmd.first ? x2 : y2;
        init = 53'(vo) <<< 1;
      end
      default: begin
        op_b = cmd.first ? d1 : d2;
        if (!cmd.pair[0]) begin
          op_a = cmd.first ? u_r : v_r;
          init = signed'(53'({c0, 17'd0}));
        end else begin
          op_a = cmd.first ? 34'(ux) : 34'(vx);
          init = '0;
        end
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) acc <= (cmd.first ? init : acc) + 53'(prod);
  end

  // writeback of a finished pair
  logic [3:0]         wm2;
  logic [1:0]         kw;
  logic signed [52:0] r10, r9;
  assign wm2 = cmd.wb_pair - 4'd2;
  assign kw  = wm2[2:1];
  assign r10 = (acc + 53'sd512) >>> 10;
  assign r9  = (acc + 53'sd256) >>> 9;

  // clamp to [0,1] and next accumulator
  logic [22:0]        cl [4];
  logic signed [24:0] nsum [4];
  logic [30:0]        a255;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (acc_c[k] < 24'sd0)            cl[k] = '0;
      else if (acc_c[k] > 24'sd4194304) cl[k] = 23'd4194304;
      else                              cl[k] = acc_c[k][22:0];
      nsum[k] = signed'({2'b00, cl[k]}) + 25'(step_c[k]);
    end
  end
  assign a255 = 31'({cl[0], 8'd0}) - 31'(cl[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      u_r <= '0;
      v_r <= '0;
      for (int k = 0; k < 4; k++) begin
        acc_c[k]  <= '0;
        step_c[k] <= '0;
      end
    end else if (cmd.wb_en) begin
      if (cmd.wb_pair == brci_pkg::PAIR_U)      u_r <= sat34(acc);
      else if (cmd.wb_pair == brci_pkg::PAIR_V) v_r <= sat34(acc);
      else if (!cmd.wb_pair[0])                 acc_c[kw]  <= sat24(r10);
      else                                      step_c[kw] <= sat24(r9);
    end else if (cmd.issue) begin
      for (int k = 0; k < 4; k++) acc_c[k] <= sat24(53'(nsum[k]));
    end
  end

  // two-stage pixel pipeline, stalls as a whole on output backpressure
  logic        en;
  logic        s1_valid, s1_last;
  logic [22:0] s1_c [1:3];
  logic [30:0] s1_a255;

  assign en       = !out_valid || out_ready;
  assign stat.adv = en;

  always_ff @(posedge clk) begin
    if (en && cmd.issue) begin
      s1_c[1] <= cl[1];
      s1_c[2] <= cl[2];
      s1_c[3] <= cl[3];
      s1_a255 <= a255;
      s1_last <= cmd.issue_last;
    end
  end

  logic [31:0] asum;
  logic [53:0] psum [1:3];
  assign asum = 32'(s1_a255) + 32'h0020_0000;
  always_comb begin
    for (int k = 1; k < 4; k++)
      psum[k] = 54'(s1_c[k]) * 54'(s1_a255) + (54'd1 << 43);
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      pixel <= {asum[29:22], psum[1][51:44], psum[2][51:44], psum[3][51:44]};
      last  <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= cmd.issue;
      out_valid <= s1_valid;
    end
  end

endmodule

/* src/barycentric_row_color_interp.sv */
// top level: barycentric color interpolation along one pixel span
// sequence: request accept, setup on the shared mac, then pixel issue into the output pipeline
// throughput: one pixel per cycle while out_ready is high; the setup of each request
//   on the shared mac (u, v, start and step per channel) sets the overhead
// a new request is taken once the last pixel of a span is issued, while it still drains
// reset: synchronous, restores map registers to identity and clears colors and pipeline
module barycentric_row_color_interp #(
  parameter int MAX_SPAN   = brci_pkg::MAX_SPAN_DEF,
  parameter int COORD_BITS = brci_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [brci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [brci_pkg::CFG_W-1:0]        cfg_data,
  // span request
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [11:0]                       start_x,
  input  logic [11:0]                       row_y,
  input  logic [6:0]                        span_count,
  // pixel results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [31:0]                       pixel,
  output logic                              last
);

  // command and status between sequencer and datapath
  brci_pkg::cmd_t  cmd;
  brci_pkg::stat_t stat;

  // sequencer: idle, mac schedule, pixel issue
  brci_ctrl #(
    .MAX_SPAN (MAX_SPAN)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .span_count (span_count),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: registers, mac, accumulators, output pipeline
  brci_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_x   (start_x),
    .row_y     (row_y),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .pixel     (pixel),
    .last      (last)
  );

endmodule

/* src/brci_chk.sv */
// port-level checker for the interpolator, bound to the top level
module brci_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [6:0]                        span_count,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [31:0]                       pixel,
  input logic                              last
);

  // reset leaves the block idle with nothing to deliver
  a_reset: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // a stalled pixel holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(last))
    else $error("pixel changed while stalled");

  // a non-empty request busies the sequencer through setup
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && span_count != 7'd0 |=> !in_ready ##20 !in_ready)
    else $error("request taken during setup");

endmodule

bind barycentric_row_color_interp brci_chk u_brci_chk (.*);

/* tb/sv/tb_barycentric_row_color_interp.sv */
// testbench for the barycentric row color interpolator: predicted pixels checked per request
module tb_barycentric_row_color_interp;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [6:0]  cnt;
  } span_req_t;

  typedef struct packed {
    logic [31:0] pix;
    logic        lst;
  } pix_res_t;

  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [brci_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [brci_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] start_x = '0;
  logic [11:0] row_y = '0;
  logic [6:0] span_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] pixel;
  logic last;

  // shadow copy of the configuration registers
  logic [63:0] shadow_cfg [0:5];

  span_req_t pending_reqs[$];
  pix_res_t  expected_pixels[$];
  int        errors = 0;
  longint    cycle_cnt = 0;
  bit        rx_hold = 1'b0;   // long receiver hold-off
  int        hold_left = 0;
  bit        drv_enable = 1'b0;
  int        tx_gap = 0;
  int        rx_gap = 0;

  always #4 clk = ~clk;

  barycentric_row_color_interp i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .row_y(row_y), .span_count(span_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel(pixel), .last(last)
  );

  function automatic longint sx32(logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // rounding shift, half toward plus infinity (arithmetic shift floors)
  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // computes every pixel of one span and queues it
  function automatic void predict_span(span_req_t r);
    longint x2, y2, ux, uy, vx, vy, uo, vo, u, v, lim, c0, d1, d2, a255, p;
    longint acc[4];
    longint stp[4];
    longint c[4];
    longint one;
    logic [31:0] pw;
    int cnt;
    pix_res_t e;
    x2 = 2 * longint'(r.x) + 1;
    y2 = 2 * longint'(r.y) + 1;
    cnt = r.cnt > brci_pkg::MAX_SPAN_DEF ? brci_pkg::MAX_SPAN_DEF : r.cnt;
    ux = sx32(shadow_cfg[brci_pkg::REG_MU][63:32]);
    uy = sx32(shadow_cfg[brci_pkg::REG_MU][31:0]);
    vx = sx32(shadow_cfg[brci_pkg::REG_MV][63:32]);
    vy = sx32(shadow_cfg[brci_pkg::REG_MV][31:0]);
    uo = sx32(shadow_cfg[brci_pkg::REG_MO][63:32]);
    vo = sx32(shadow_cfg[brci_pkg::REG_MO][31:0]);
    lim = longint'(1) << 33;
    u = clip(ux * x2 + uy * y2 + 2 * uo, -lim, lim - 1);
    v = clip(vx * x2 + vy * y2 + 2 * vo, -lim, lim - 1);
    for (int k = 0; k < 4; k++) begin
      c0 = longint'(shadow_cfg[brci_pkg::REG_CV0][48-16*k +: 16]);
      d1 = longint'(shadow_cfg[brci_pkg::REG_CV1][48-16*k +: 16]) - c0;
      d2 = longint'(shadow_cfg[brci_pkg::REG_CV2][48-16*k +: 16]) - c0;
      acc[k] = clip(rshift_round(c0 * (longint'(1) << 17) + u * d1 + v * d2, 10),
                    -(longint'(1) << 23), (longint'(1) << 23) - 1);
      stp[k] = clip(rshift_round(ux * d1 + vx * d2, 9),
                    -(longint'(1) << 23), (longint'(1) << 23) - 1);
    end
    one = longint'(1) << 22;
    for (int n = cnt; n > 0; n--) begin
      for (int k = 0; k < 4; k++) c[k] = clip(acc[k], 0, one);
      a255 = c[0] * 255;
      pw = '0;
      pw[31:24] = 8'((a255 + (longint'(1) << 21)) >> 22);
      for (int k = 1; k < 4; k++) begin
        p = c[k] * a255;
        pw[8*(3-k) +: 8] = 8'((p + (longint'(1) << 43)) >> 44);
      end
      e.pix = pw;
      e.lst = (n == 1);
      expected_pixels.push_back(e);
      for (int k = 0; k < 4; k++)
        acc[k] = clip(c[k] + stp[k], -(longint'(1) << 23), (longint'(1) << 23) - 1);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: presents queued requests, predicts on accept
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_span(pending_reqs.pop_front());
        tx_gap = pick_gap();
      end
      if (in_valid && !in_ready) begin
        // hold the request until it is taken
      end else if (drv_enable && pending_reqs.size() > 0 && tx_gap == 0) begin
        in_valid <= 1'b1;
        start_x <= pending_reqs[0].x;
        row_y <= pending_reqs[0].y;
        span_count <= pending_reqs[0].cnt;
      end else begin
        in_valid <= 1'b0;
        if (tx_gap > 0) tx_gap--;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    pix_res_t e;
    cycle_cnt++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %h last %b", $time, pixel, last);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (pixel !== e.pix) begin
            $display("%0t: pixel mismatch expected %h actual %h", $time, e.pix, pixel);
            errors++;
          end
          if (last !== e.lst) begin
            $display("%0t: last mismatch expected %b actual %b", $time, e.lst, last);
            errors++;
          end
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(brci_pkg::cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    shadow_cfg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic void add_req(logic [11:0] x, logic [11:0] y, logic [6:0] c);
    span_req_t r;
    r.x = x; r.y = y; r.cnt = c;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // affine row with small coefficients so u, v stay near the triangle
  function automatic logic [63:0] small_pair();
    int a, b;
    a = $urandom_range(0, 512) - 256;
    b = $urandom_range(0, 512) - 256;
    return {32'(a), 32'(b)};
  endfunction

  function automatic void random_reqs(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_req(12'($urandom()), 12'($urandom()), 7'($urandom_range(0, 127)));
      else
        add_req(12'($urandom_range(0, 255)), 12'($urandom_range(0, 255)),
                7'($urandom_range(1, 12)));
    end
  endfunction

  initial begin
    shadow_cfg[0] = '0; shadow_cfg[1] = '0; shadow_cfg[2] = '0;
    shadow_cfg[3] = 64'h0001_0000_0000_0000;
    shadow_cfg[4] = 64'h0000_0000_0001_0000;
    shadow_cfg[5] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: black everywhere
    drv_enable = 1'b1;
    add_req(12'd0, 12'd0, 7'd1);
    wait_idle();

    // directed: full-scale colors, fixed map coefficients, field extremes
    write_reg(brci_pkg::REG_CV0, 64'h8000_0000_0000_0000);
    write_reg(brci_pkg::REG_CV1, 64'hffff_8000_ffff_0000);
    write_reg(brci_pkg::REG_CV2, 64'h4000_0000_8000_ffff);
    write_reg(brci_pkg::REG_MU, {32'sd4096, -32'sd2048});
    write_reg(brci_pkg::REG_MV, {-32'sd1024, 32'sd512});
    write_reg(brci_pkg::REG_MO, {32'sd16384, -32'sd8192});
    add_req(12'd0, 12'd0, 7'd1);
    add_req(12'hfff, 12'hfff, 7'd64);
    add_req(12'h800, 12'h001, 7'd0);     // empty span
    add_req(12'h7ff, 12'h555, 7'd127);   // long span cut to the maximum
    add_req(12'haaa, 12'h800, 7'd65);
    add_req(12'd3, 12'd5, 7'd2);
    wait_idle();

    // huge map results: u, v and step saturate
    write_reg(brci_pkg::REG_MU, 64'h7fff_ffff_7fff_ffff);
    write_reg(brci_pkg::REG_MV, 64'h8000_0000_8000_0000);
    write_reg(brci_pkg::REG_MO, 64'h7fff_ffff_8000_0000);
    write_reg(brci_pkg::REG_CV0, 64'h0);
    write_reg(brci_pkg::REG_CV1, 64'hffff_ffff_ffff_ffff);
    write_reg(brci_pkg::REG_CV2, 64'h0);
    add_req(12'hfff, 12'h0, 7'd4);
    add_req(12'h0, 12'hfff, 7'd3);
    add_req(12'h123, 12'h456, 7'd1);
    wait_idle();

    // pressure: receiver holds off while requests keep coming
    write_reg(brci_pkg::REG_MU, {32'sd2048, 32'sd0});
    write_reg(brci_pkg::REG_MV, {32'sd0, 32'sd2048});
    write_reg(brci_pkg::REG_MO, 64'h0);
    rx_hold = 1'b1;
    random_reqs(6);
    hold_left = 300;
    while (hold_left > 0) begin
      @(posedge clk);
      hold_left--;
    end
    rx_hold = 1'b0;
    wait_idle();

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(brci_pkg::REG_CV0, rand64());
      write_reg(brci_pkg::REG_CV1, rand64());
      write_reg(brci_pkg::REG_CV2, rand64());
      if (ph % 3 == 0) begin
        write_reg(brci_pkg::REG_MU, rand64());
        write_reg(brci_pkg::REG_MV, rand64());
        write_reg(brci_pkg::REG_MO, rand64());
      end else begin
        write_reg(brci_pkg::REG_MU, small_pair());
        write_reg(brci_pkg::REG_MV, small_pair());
        write_reg(brci_pkg::REG_MO,
                  {32'($urandom_range(0, 65536)), 32'($urandom_range(0, 65536))});
      end
      random_reqs(20);
      wait_idle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
